### design/sha1_message_digest_assert.svh
// ----------------------------------------------------------------------------
// SHA-1 digest assertion macros
// Clocked implication checks shared by the digest block.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA_ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("sha1 check failed");
`define SHA_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("sha1 check failed");
`endif

### design/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 package
// Round constants, initial hash values, the pad marker and a rotate-left helper.
// ----------------------------------------------------------------------------
package sha_pkg;
	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [31:0] IV [5] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe,
		32'h10325476, 32'hc3d2e1f0};

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction
endpackage

### design/sha1_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Byte-stream SHA-1 hash with the message schedule held in a memory.
// ----------------------------------------------------------------------------
// Usage:
// s_axis takes one request per cycle while tready is high: tdata carries
// data_byte, tuser is byte_valid and tlast is last_item. Bytes are packed
// big-endian into the 16-word schedule memory. After the 64th byte of a
// block s_axis is held off while the block is compressed: a prime state
// starts the memory read, 80 rounds run one per cycle, and a fold state
// adds the working values into the hash.
// On tlast the block writes 0x80, zero fill and the 64-bit length, one
// pad byte a cycle, and compresses one or two more blocks before the
// first digest word appears on m_axis.
// m_axis then carries five requests: tdata is digest_word, tuser is
// word_index, tlast marks the fifth word. A stalled m_axis holds the
// current word; s_axis stays closed until the fifth word is taken.
// Reset restores the initial hash and clears all counters; the schedule
// memory is not cleared, since every word is written before it is read.
module sha1_message_digest
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] byte_valid
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,  // [2:0] word_index
	output logic        m_axis_tlast
);
	typedef enum logic [2:0] {S_IDLE, S_PAD, S_PRIME, S_ROUND, S_FOLD, S_OUT} state_t;
	state_t      state_q;
	logic [31:0] h_q [5];
	logic [31:0] v_q [5];
	logic [5:0]  pos_q;
	logic [63:0] len_q;
	logic [63:0] plen_q;
	logic [6:0]  rnd_q;
	logic        pad_q;
	logic        mark_q;
	logic        fin_q;
	logic [2:0]  oidx_q;
	logic [23:0] wbuf_q;
	logic [31:0] mem [16];
	logic [31:0] rd_q [4];

	logic        in_fire;
	logic        byte_en;
	logic [7:0]  byte_in;
	logic [7:0]  pbyte;
	logic [6:0]  nrnd;
	logic [3:0]  raddr [4];
	logic [31:0] w_t;
	logic [31:0] f;
	logic [31:0] t_sum;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata = h_q[oidx_q];
	assign m_axis_tuser = oidx_q;
	assign m_axis_tlast = (oidx_q == 3'd4);

	always_comb begin
		if (mark_q) pbyte = PAD_MARK;
		else if (fin_q && pos_q >= 6'd56) pbyte = plen_q[63:56];
		else pbyte = 8'h00;
		byte_en = (in_fire && s_axis_tuser) || (state_q == S_PAD);
		byte_in = (state_q == S_PAD) ? pbyte : s_axis_tdata;
		nrnd = (state_q == S_ROUND) ? rnd_q + 7'd1 : 7'd0;
		raddr[0] = nrnd[3:0] - 4'd3;
		raddr[1] = nrnd[3:0] - 4'd8;
		raddr[2] = nrnd[3:0] - 4'd14;
		raddr[3] = nrnd[3:0];
		if (rnd_q < 7'd16) w_t = rd_q[3];
		else w_t = rotl(rd_q[0] ^ rd_q[1] ^ rd_q[2] ^ rd_q[3], 1);
		if (rnd_q < 7'd20) f = ((v_q[1] & v_q[2]) | (~v_q[1] & v_q[3])) + K0;
		else if (rnd_q < 7'd40) f = (v_q[1] ^ v_q[2] ^ v_q[3]) + K1;
		else if (rnd_q < 7'd60)
			f = ((v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3])) + K2;
		else f = (v_q[1] ^ v_q[2] ^ v_q[3]) + K3;
		t_sum = f + rotl(v_q[0], 5) + v_q[4] + w_t;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) rd_q[k] <= mem[raddr[k]];
		if (byte_en && pos_q[1:0] == 2'd3) mem[pos_q[5:2]] <= {wbuf_q, byte_in};
		else if (state_q == S_ROUND && rnd_q >= 7'd16) mem[rnd_q[3:0]] <= w_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < 5; i++) h_q[i] <= IV[i];
			for (int i = 0; i < 5; i++) v_q[i] <= '0;
			pos_q <= '0; len_q <= '0; plen_q <= '0; rnd_q <= '0;
			pad_q <= 1'b0; mark_q <= 1'b0; fin_q <= 1'b0; oidx_q <= '0; wbuf_q <= '0;
		end else begin
			if (byte_en) begin
				wbuf_q <= {wbuf_q[15:0], byte_in};
				pos_q <= pos_q + 6'd1;
			end
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					if (s_axis_tuser) len_q <= len_q + 64'd8;
					if (s_axis_tlast) begin
						pad_q <= 1'b1; mark_q <= 1'b1; fin_q <= 1'b0;
						plen_q <= s_axis_tuser ? len_q + 64'd8 : len_q;
					end
					if (s_axis_tuser && pos_q == 6'd63) state_q <= S_PRIME;
					else if (s_axis_tlast) state_q <= S_PAD;
				end
				S_PAD: begin
					mark_q <= 1'b0;
					if (mark_q) fin_q <= (pos_q < 6'd56);
					else if (fin_q && pos_q >= 6'd56) plen_q <= {plen_q[55:0], 8'h00};
					if (pos_q == 6'd63) state_q <= S_PRIME;
				end
				S_PRIME: begin
					for (int i = 0; i < 5; i++) v_q[i] <= h_q[i];
					rnd_q <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					v_q[0] <= t_sum; v_q[1] <= v_q[0]; v_q[2] <= rotl(v_q[1], 30);
					v_q[3] <= v_q[2]; v_q[4] <= v_q[3];
					if (rnd_q == 7'd79) begin
						rnd_q <= '0;
						state_q <= S_FOLD;
					end else rnd_q <= rnd_q + 7'd1;
				end
				S_FOLD: begin
					for (int i = 0; i < 5; i++) h_q[i] <= h_q[i] + v_q[i];
					if (!pad_q) state_q <= S_IDLE;
					else if (fin_q) state_q <= S_OUT;
					else begin
						if (!mark_q) fin_q <= 1'b1;
						state_q <= S_PAD;
					end
				end
				S_OUT: if (m_axis_tready) begin
					if (oidx_q == 3'd4) begin
						state_q <= S_IDLE;
						for (int i = 0; i < 5; i++) h_q[i] <= IV[i];
						oidx_q <= '0; len_q <= '0; pad_q <= 1'b0; fin_q <= 1'b0;
					end else oidx_q <= oidx_q + 3'd1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "sha1_message_digest_assert.svh"
	`SHA_ASSERT_IMPL(a_no_in_out, m_axis_tvalid, !s_axis_tready)
	`SHA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`SHA_ASSERT_NEXT(a_word_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`SHA_ASSERT_IMPL(a_idx_range, m_axis_tvalid, oidx_q <= 3'd4)
endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 digest testbench
// Streams messages into sha1_message_digest and checks each digest word
// against an in-bench SHA-1 predictor, or a known digest where a table row
// gives one. A short fixed table first, then random messages, some with
// lengths near the padding boundaries. Bursty sender, stalling receiver.
// ----------------------------------------------------------------------------
module tb
	import sha_pkg::*;
;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	typedef struct {
		logic [7:0]   data;
		logic         valid;
		logic         last;
		bit           typed;
		logic [159:0] digest;
	} msg_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	digest_word_t digest_q[$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	int rx_mode = 0;

	logic [31:0] hash_st[5];
	logic [31:0] sched[16];
	int          byte_pos;
	logic [63:0] msg_bits;

	msg_row_t rows[12];

	sha1_message_digest dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic report(input string msg);
		$display("tb: mismatch: %s", msg);
		errors++;
	endtask

	// receiver: check and stall on a changing pattern
	always @(posedge clk) begin
		digest_word_t exp_w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (digest_q.size() == 0)
				report($sformatf("unexpected word %h", m_axis_tdata));
			else begin
				exp_w = digest_q.pop_front();
				if (m_axis_tdata !== exp_w.word)
					report($sformatf("word %0d: got %h want %h", exp_w.idx,
						m_axis_tdata, exp_w.word));
				if (m_axis_tuser !== exp_w.idx)
					report($sformatf("index: got %0d want %0d", m_axis_tuser,
						exp_w.idx));
				if (m_axis_tlast !== exp_w.last)
					report($sformatf("last flag on word %0d: got %b", exp_w.idx,
						m_axis_tlast));
			end
		end
		if ($urandom_range(0, 63) == 0)
			rx_mode = $urandom_range(0, 2);
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic hash_reset();
		foreach (hash_st[i])
			hash_st[i] = IV[i];
		byte_pos = 0;
		msg_bits = '0;
	endtask

	task automatic compress();
		logic [31:0] a, b, c, d, e, w, f;
		a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3]; e = hash_st[4];
		for (int t = 0; t < 80; t++) begin
			if (t >= 16) begin
				w = rol(sched[(t - 3) & 15] ^ sched[(t - 8) & 15] ^ sched[(t - 14) & 15]
					^ sched[t & 15], 1);
				sched[t & 15] = w;
			end else
				w = sched[t];
			if (t < 20)
				f = ((b & c) | (~b & d)) + K0;
			else if (t < 40)
				f = (b ^ c ^ d) + K1;
			else if (t < 60)
				f = ((b & c) | (b & d) | (c & d)) + K2;
			else
				f = (b ^ c ^ d) + K3;
			f = f + rol(a, 5) + e + w;
			e = d; d = c; c = rol(b, 30); b = a; a = f;
		end
		hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
		hash_st[4] += e;
	endtask

	task automatic absorb_byte(input logic [7:0] v);
		int sh;
		sh = (3 - (byte_pos & 3)) * 8;
		if ((byte_pos & 3) == 0)
			sched[byte_pos >> 2] = 32'(v) << sh;
		else
			sched[byte_pos >> 2] |= 32'(v) << sh;
		byte_pos = (byte_pos + 1) & 63;
		if (byte_pos == 0)
			compress();
	endtask

	// advance the predictor by one request; queue the digest on the final one
	task automatic predict_digest(input logic [7:0] d, input logic v, input logic l);
		logic [63:0] len;
		digest_word_t w;
		if (v) begin
			absorb_byte(d);
			msg_bits += 64'd8;
		end
		if (l) begin
			len = msg_bits;
			absorb_byte(PAD_MARK);
			while (byte_pos != 56)
				absorb_byte(8'h00);
			for (int i = 0; i < 8; i++)
				absorb_byte(len[63 - 8 * i -: 8]);
			for (int i = 0; i < 5; i++) begin
				w.word = hash_st[i];
				w.idx = 3'(i);
				w.last = (i == 4);
				digest_q.insert(digest_q.size(), w);
			end
			hash_reset();
		end
	endtask

	task automatic send(input logic [7:0] d, input logic v, input logic l);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tuser <= v;
		s_axis_tlast <= l;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (digest_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int len;
		int items;
		bit sep_last;
		digest_word_t w;

		rows[0]  = '{8'h00, 1'b0, 1'b1, 1'b1,
			160'hda39a3ee5e6b4b0d3255bfef95601890afd80709};
		rows[1]  = '{8'hff, 1'b0, 1'b0, 1'b0, '0};
		rows[2]  = '{8'h61, 1'b1, 1'b0, 1'b0, '0};
		rows[3]  = '{8'h00, 1'b0, 1'b0, 1'b0, '0};
		rows[4]  = '{8'h62, 1'b1, 1'b0, 1'b0, '0};
		rows[5]  = '{8'h63, 1'b1, 1'b1, 1'b1,
			160'ha9993e364706816aba3e25717850c26c9cd0d89d};
		rows[6]  = '{8'hff, 1'b1, 1'b0, 1'b0, '0};
		rows[7]  = '{8'h00, 1'b1, 1'b0, 1'b0, '0};
		rows[8]  = '{8'hff, 1'b0, 1'b1, 1'b0, '0};
		rows[9]  = '{8'hff, 1'b1, 1'b1, 1'b0, '0};
		rows[10] = '{8'h00, 1'b1, 1'b1, 1'b0, '0};
		rows[11] = '{8'h5a, 1'b0, 1'b1, 1'b0, '0};

		hash_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r]) begin
			send(rows[r].data, rows[r].valid, rows[r].last);
			if (rows[r].typed) begin
				predict_digest(rows[r].data, rows[r].valid, rows[r].last);
				repeat (5) void'(digest_q.pop_back());
				for (int i = 0; i < 5; i++) begin
					w.word = rows[r].digest[159 - 32 * i -: 32];
					w.idx = 3'(i);
					w.last = (i == 4);
					digest_q.insert(digest_q.size(), w);
				end
			end else
				predict_digest(rows[r].data, rows[r].valid, rows[r].last);
		end
		drain();

		items = 0;
		while (items < 200) begin
			case ($urandom_range(0, 9))
				0: len = 55;
				1: len = 56;
				2: len = 63;
				3: len = 64;
				4: len = $urandom_range(119, 121);
				default: len = $urandom_range(0, 12);
			endcase
			if (len > 201 - items)
				len = 201 - items;
			sep_last = (len == 0) || $urandom_range(0, 1);
			for (int i = 0; i < len; i++) begin
				logic [7:0] b;
				b = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 15) == 0) begin
					send(8'($urandom), 1'b0, 1'b0);
					predict_digest(s_axis_tdata, 1'b0, 1'b0);
				end
				send(b, 1'b1, !sep_last && i == len - 1);
				predict_digest(b, 1'b1, !sep_last && i == len - 1);
				items++;
			end
			if (sep_last) begin
				logic [7:0] b;
				b = 8'($urandom_range(0, 255));
				send(b, 1'b0, 1'b1);
				predict_digest(b, 1'b0, 1'b1);
				items++;
			end
			if ($urandom_range(0, 7) == 0)
				drain();
		end

		drain();
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
